// ===== hw/rtl/itp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types and constants of the integer text parser: character codes,
// base codes, configuration register indexes and the queue entry format.
// ----------------------------------------------------------------------------
package itp_pkg;

  // port widths of the result fields
  localparam int unsigned OUT_VALUE_W = 64;
  localparam int unsigned OUT_COUNT_W = 16;

  // configuration port
  localparam int unsigned CFG_DATA_W = 6;
  localparam logic REG_BASE   = 1'b0;
  localparam logic REG_SIGNED = 1'b1;

  // base codes
  localparam logic [5:0] BASE_AUTO = 6'd0;
  localparam logic [5:0] BASE_ONE  = 6'd1;
  localparam logic [5:0] BASE_MIN  = 6'd2;
  localparam logic [5:0] BASE_OCT  = 6'd8;
  localparam logic [5:0] BASE_DEC  = 6'd10;
  localparam logic [5:0] BASE_HEX  = 6'd16;
  localparam logic [5:0] BASE_MAX  = 6'd36;

  // character codes
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // digit codes: letters map to 10..35, x/X is 33, anything else no digit
  localparam logic [5:0] DIGIT_ZERO = 6'd0;
  localparam logic [5:0] DIGIT_X    = 6'd33;
  localparam logic [5:0] NO_DIGIT   = 6'h3F;
  localparam logic [5:0] LETTER_OFS = 6'd10;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // classified character
  typedef struct packed {
    logic [5:0] digit;
    logic       is_space;
    logic       is_plus;
    logic       is_minus;
    logic       start;
    logic       last;
  } entry_t;

endpackage
`default_nettype wire

// ===== hw/rtl/itp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itp_front
// Input side: takes character transfers while the queue has room and
// classifies each character into digit value, whitespace and sign flags.
// ----------------------------------------------------------------------------
module itp_front (
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [7:0]     in_chr,
  input  wire logic           in_start_req,
  input  wire logic           in_last,
  input  wire logic           q_full,
  output logic                q_push,
  output itp_pkg::entry_t     q_entry
);

  logic [5:0] digit;

  // digit value of the character
  always_comb begin
    digit = itp_pkg::NO_DIGIT;
    if (in_chr >= itp_pkg::CH_0 && in_chr <= itp_pkg::CH_9) begin
      digit = 6'(in_chr - itp_pkg::CH_0);
    end else if (in_chr >= itp_pkg::CH_LA && in_chr <= itp_pkg::CH_LZ) begin
      digit = 6'(in_chr - itp_pkg::CH_LA) + itp_pkg::LETTER_OFS;
    end else if (in_chr >= itp_pkg::CH_UA && in_chr <= itp_pkg::CH_UZ) begin
      digit = 6'(in_chr - itp_pkg::CH_UA) + itp_pkg::LETTER_OFS;
    end
  end

  // entry for the queue
  always_comb begin
    q_entry.digit    = digit;
    q_entry.is_space = (in_chr == itp_pkg::CH_SPACE) ||
                       (in_chr >= itp_pkg::CH_TAB && in_chr <= itp_pkg::CH_CR);
    q_entry.is_plus  = (in_chr == itp_pkg::CH_PLUS);
    q_entry.is_minus = (in_chr == itp_pkg::CH_MINUS);
    q_entry.start    = in_start_req;
    q_entry.last     = in_last;
  end

  // handshake
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule
`default_nettype wire

// ===== hw/rtl/itp_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itp_fifo
// Short queue of classified characters between the front and the back.
// ----------------------------------------------------------------------------
module itp_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire itp_pkg::entry_t push_entry,
  output logic                 full,
  input  wire logic            pop,
  output logic                 not_empty,
  output itp_pkg::entry_t      head
);

  localparam int unsigned DEPTH = itp_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  itp_pkg::entry_t   mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/itp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itp_back
// Parse engine: walks the prefix/sign/digit state machine one character a
// cycle unless queue is empty or output stalled, multiply-accumulates digits
// with overflow check and holds the result in an output register until taken.
// ----------------------------------------------------------------------------
module itp_back #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [5:0]                         base_cfg,
  input  wire logic                               signed_cfg,
  input  wire logic                               q_valid,
  input  wire itp_pkg::entry_t                    q_entry,
  output logic                                    q_pop,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [itp_pkg::OUT_VALUE_W-1:0]         out_value,
  output logic [itp_pkg::OUT_COUNT_W-1:0]         out_consumed,
  output logic                                    out_range_error,
  output logic                                    out_digits_found
);

  localparam int unsigned VW  = VALUE_WIDTH;
  localparam int unsigned CW  = COUNT_WIDTH;
  localparam int unsigned MW  = VW + 6;
  localparam int unsigned PXW = CW + itp_pkg::OUT_COUNT_W;
  localparam logic [VW-1:0] SMAX = {1'b0, {(VW - 1){1'b1}}};
  localparam logic [VW-1:0] SMIN = {1'b1, {(VW - 1){1'b0}}};

  typedef enum logic [5:0] {
    PH_LEAD   = 6'b000001,
    PH_FIRST  = 6'b000010,
    PH_ZERO   = 6'b000100,
    PH_XSEEN  = 6'b001000,
    PH_DIGITS = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  // parse state
  phase_t          phase_r, phase_nxt, phase_cur;
  logic            neg_r, neg_nxt, neg_cur;
  logic [5:0]      ebase_r, ebase_nxt, ebase_cur;
  logic [VW-1:0]   acc_r, acc_nxt, acc_cur;
  logic            ovf_r, ovf_nxt, ovf_cur;
  logic            have_r, have_nxt, have_cur;
  logic [CW-1:0]   pos_r, pos_nxt, pos_cur;

  // result register
  logic            out_valid_r, out_valid_nxt;
  logic [VW-1:0]   res_acc_r;
  logic            res_neg_r, res_ovf_r, res_have_r, res_signed_r;
  logic [CW-1:0]   res_pos_r;

  logic            fire, emit, active, ends, take, first;
  logic            bad_base, zero_prefix;
  logic [1:0]      inc;
  logic [CW:0]     pos_sum;
  logic [MW-1:0]   mac;
  logic [VW-1:0]   limit;
  logic [VW-1:0]   res_val;
  logic [PXW-1:0]  pos_ext;

  assign fire  = q_valid && (!out_valid_r || !out_stall);
  assign q_pop = fire;

  // a start request clears state before the character is taken
  always_comb begin
    if (q_entry.start) begin
      phase_cur = PH_LEAD;
      neg_cur   = 1'b0;
      ebase_cur = '0;
      acc_cur   = '0;
      ovf_cur   = 1'b0;
      have_cur  = 1'b0;
      pos_cur   = '0;
    end else begin
      phase_cur = phase_r;
      neg_cur   = neg_r;
      ebase_cur = ebase_r;
      acc_cur   = acc_r;
      ovf_cur   = ovf_r;
      have_cur  = have_r;
      pos_cur   = pos_r;
    end
  end

  // phase machine, digit accumulate and overflow check
  always_comb begin
    phase_nxt   = phase_cur;
    neg_nxt     = neg_cur;
    ebase_nxt   = ebase_cur;
    acc_nxt     = acc_cur;
    ovf_nxt     = ovf_cur;
    have_nxt    = have_cur;
    inc         = 2'd0;
    ends        = 1'b0;
    take        = 1'b0;
    first       = 1'b0;
    active      = 1'b1;
    bad_base    = (base_cfg == itp_pkg::BASE_ONE) || (base_cfg > itp_pkg::BASE_MAX);
    zero_prefix = (q_entry.digit == itp_pkg::DIGIT_ZERO) &&
                  ((base_cfg == itp_pkg::BASE_AUTO) || (base_cfg == itp_pkg::BASE_HEX));

    case (phase_cur)
      PH_LEAD: begin
        if (q_entry.is_space) begin
          inc = 2'd1;
        end else if (q_entry.is_plus || q_entry.is_minus) begin
          neg_nxt   = q_entry.is_minus;
          inc       = 2'd1;
          phase_nxt = PH_FIRST;
        end else begin
          first = 1'b1;
        end
      end
      PH_FIRST: begin
        first = 1'b1;
      end
      PH_ZERO: begin
        if (q_entry.digit == itp_pkg::DIGIT_X) begin
          phase_nxt = PH_XSEEN;
        end else begin
          phase_nxt = PH_DIGITS;
          take      = 1'b1;
        end
      end
      PH_XSEEN: begin
        if (q_entry.digit < itp_pkg::BASE_HEX) begin
          // the deferred x counts together with the first hex digit
          ebase_nxt = itp_pkg::BASE_HEX;
          inc       = 2'd1;
          phase_nxt = PH_DIGITS;
          take      = 1'b1;
        end else begin
          ends = 1'b1;
        end
      end
      PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
        active = 1'b0;
      end
    endcase

    // first character of the number: base check, base selection and zero prefix
    if (first) begin
      if (bad_base) begin
        ends = 1'b1;
      end else if (zero_prefix) begin
        have_nxt  = 1'b1;
        acc_nxt   = '0;
        ebase_nxt = (base_cfg == itp_pkg::BASE_HEX) ? itp_pkg::BASE_HEX
                                                    : itp_pkg::BASE_OCT;
        inc       = 2'd1;
        phase_nxt = PH_ZERO;
      end else begin
        ebase_nxt = (base_cfg == itp_pkg::BASE_AUTO) ? itp_pkg::BASE_DEC : base_cfg;
        phase_nxt = PH_DIGITS;
        take      = 1'b1;
      end
    end

    // overflow limit for the current sign and mode
    if (signed_cfg) begin
      limit = neg_cur ? SMIN : SMAX;
    end else begin
      limit = '1;
    end

    // acc * base + digit, overflow when it passes the limit
    mac = MW'(acc_cur) * MW'(ebase_nxt) + MW'(q_entry.digit);
    if (take) begin
      if ((q_entry.digit >= ebase_nxt) || (ebase_nxt < itp_pkg::BASE_MIN)) begin
        ends = 1'b1;
      end else begin
        if (!ovf_cur) begin
          if (mac > MW'(limit)) begin
            ovf_nxt = 1'b1;
          end else begin
            acc_nxt = mac[VW-1:0];
          end
        end
        have_nxt = 1'b1;
        inc      = inc + 2'd1;
      end
    end

    emit = active && (ends || q_entry.last);
    if (emit) begin
      phase_nxt = PH_DONE;
    end
  end

  // saturating position count
  always_comb begin
    pos_sum = {1'b0, pos_cur} + (CW + 1)'(inc);
    if (pos_sum > {1'b0, {CW{1'b1}}}) begin
      pos_nxt = '1;
    end else begin
      pos_nxt = pos_sum[CW-1:0];
    end
  end

  // output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire && emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      neg_r       <= 1'b0;
      ebase_r     <= '0;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      have_r      <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        ebase_r <= ebase_nxt;
        acc_r   <= acc_nxt;
        ovf_r   <= ovf_nxt;
        have_r  <= have_nxt;
        pos_r   <= pos_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire && emit) begin
      res_acc_r    <= acc_nxt;
      res_neg_r    <= neg_nxt;
      res_ovf_r    <= ovf_nxt;
      res_have_r   <= have_nxt;
      res_signed_r <= signed_cfg;
      res_pos_r    <= pos_nxt;
    end
  end

  // final value: saturation or sign applied after the register
  always_comb begin
    if (!res_have_r) begin
      res_val = '0;
    end else if (res_ovf_r) begin
      if (res_signed_r) begin
        res_val = res_neg_r ? SMIN : SMAX;
      end else begin
        res_val = '1;
      end
    end else if (res_neg_r) begin
      res_val = '0 - res_acc_r;
    end else begin
      res_val = res_acc_r;
    end
  end

  assign pos_ext          = PXW'(res_pos_r);
  assign out_valid        = out_valid_r;
  assign out_value        = itp_pkg::OUT_VALUE_W'(res_val);
  assign out_consumed     = res_have_r ? pos_ext[itp_pkg::OUT_COUNT_W-1:0] : '0;
  assign out_range_error  = res_have_r && res_ovf_r;
  assign out_digits_found = res_have_r;

endmodule
`default_nettype wire

// ===== hw/rtl/integer_text_parser.sv =====
// Path: an accepted character transfer is written into the queue, taken by the
// parse engine from the queue head, and its result registered for out_valid.
// Throughput: one character per cycle, set by the single parse engine and
// its multiply-accumulate over the queue head; a stalled output holds it.
// Reset: clears queue, parse state and output; base = 0 (auto), signed = 1.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_text_parser
// Streaming integer text parser: character front end, queue, and parse
// engine with base detection, sign handling and saturation.
// ----------------------------------------------------------------------------
module integer_text_parser #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // character channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [7:0]                           in_chr,
  input  wire logic                                 in_start_req,
  input  wire logic                                 in_last,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [itp_pkg::OUT_VALUE_W-1:0]           out_value,
  output logic [itp_pkg::OUT_COUNT_W-1:0]           out_consumed,
  output logic                                      out_range_error,
  output logic                                      out_digits_found,
  // configuration write
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic                                 cfg_index,
  input  wire logic [itp_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic [5:0]      base_r;
  logic            signed_r;
  logic            q_push, q_full, q_pop, q_valid;
  itp_pkg::entry_t push_entry, head_entry;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= itp_pkg::BASE_AUTO;
      signed_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        itp_pkg::REG_BASE:   base_r   <= cfg_data[5:0];
        itp_pkg::REG_SIGNED: signed_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // character classification and input transfer
  itp_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_chr       (in_chr),
    .in_start_req (in_start_req),
    .in_last      (in_last),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (push_entry)
  );

  // queue between front and back
  itp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_valid),
    .head       (head_entry)
  );

  // parse engine and result register
  itp_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .base_cfg         (base_r),
    .signed_cfg       (signed_r),
    .q_valid          (q_valid),
    .q_entry          (head_entry),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value        (out_value),
    .out_consumed     (out_consumed),
    .out_range_error  (out_range_error),
    .out_digits_found (out_digits_found)
  );

endmodule
`default_nettype wire

// ===== sim/tb_integer_text_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_text_parser
// Self-checking bench for the streaming integer text parser. Strings are fed
// one character per transfer; a behavioral parser predicts each result, and
// every result transfer is compared field by field against the oldest
// prediction. Directed strings cover prefixes, signs, saturation and invalid
// bases; random strings with near-limit values run under several base/sign
// settings and input/output idling mixes.
// ----------------------------------------------------------------------------
module tb_integer_text_parser;

  // characters not in the package, value and count limits, items per mix
  localparam logic [7:0] CH_LX = 8'h78;
  localparam logic [7:0] CH_UX = 8'h58;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [63:0] SIGNED_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] SIGNED_MIN = 64'h8000_0000_0000_0000;
  localparam logic [15:0] COUNT_MAX = 16'hffff;
  localparam int unsigned ITEMS_PER_MIX = 400;

  typedef enum logic [2:0] {
    ST_LEAD, ST_SIGNED, ST_ZERO, ST_XSEEN, ST_DIGITS, ST_DONE
  } parse_state_t;

  typedef struct packed {
    logic [itp_pkg::OUT_VALUE_W-1:0] value;
    logic [itp_pkg::OUT_COUNT_W-1:0] consumed;
    logic                            range_error;
    logic                            digits_found;
  } parse_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [7:0]                      in_chr = '0;
  logic                            in_start_req = 1'b0;
  logic                            in_last = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [itp_pkg::OUT_VALUE_W-1:0] out_value;
  logic [itp_pkg::OUT_COUNT_W-1:0] out_consumed;
  logic                            out_range_error;
  logic                            out_digits_found;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic                            cfg_index = itp_pkg::REG_BASE;
  logic [itp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // behavioral parser state and its copy of the registers
  parse_state_t p_state = ST_LEAD;
  bit           p_neg = 1'b0;
  logic [5:0]   p_base = '0;
  logic [63:0]  p_acc = '0;
  bit           p_ovf = 1'b0;
  bit           p_have = 1'b0;
  logic [15:0]  p_pos = '0;
  logic [5:0]   cfg_base_q = itp_pkg::BASE_AUTO;
  bit           cfg_signed_q = 1'b1;

  parse_result_t pending_results[$];
  logic [7:0]    text_q[$];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned strings_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned live_chars = 0;

  integer_text_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_chr           (in_chr),
    .in_start_req     (in_start_req),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value        (out_value),
    .out_consumed     (out_consumed),
    .out_range_error  (out_range_error),
    .out_digits_found (out_digits_found),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $display("run limit reached with %0d results outstanding", pending_results.size());
    $finish;
  end

  // ---------------------------------------------------------------------------
  // behavioral parser
  // ---------------------------------------------------------------------------

  function automatic logic [5:0] digit_value(input logic [7:0] c);
    if (c >= itp_pkg::CH_0 && c <= itp_pkg::CH_9) return 6'(c - itp_pkg::CH_0);
    if (c >= itp_pkg::CH_LA && c <= itp_pkg::CH_LZ)
      return 6'(c - itp_pkg::CH_LA) + itp_pkg::LETTER_OFS;
    if (c >= itp_pkg::CH_UA && c <= itp_pkg::CH_UZ)
      return 6'(c - itp_pkg::CH_UA) + itp_pkg::LETTER_OFS;
    return itp_pkg::NO_DIGIT;
  endfunction

  function automatic void bump_position();
    if (p_pos != COUNT_MAX) p_pos = p_pos + 16'd1;
  endfunction

  // multiply-accumulate one digit; 0 when the character is not a digit here
  function automatic bit accept_digit(input logic [7:0] c);
    logic [5:0]  d;
    logic [63:0] limit;
    d = digit_value(c);
    if (d >= p_base || p_base < itp_pkg::BASE_MIN) return 1'b0;
    if (!p_ovf) begin
      limit = cfg_signed_q ? SIGNED_MAX + (p_neg ? 64'd1 : 64'd0) : '1;
      if (p_acc > (limit - 64'(d)) / 64'(p_base)) p_ovf = 1'b1;
      else p_acc = p_acc * 64'(p_base) + 64'(d);
    end
    p_have = 1'b1;
    bump_position();
    return 1'b1;
  endfunction

  // first character after whitespace and sign; 1 when it ends the number
  function automatic bit begin_number(input logic [7:0] c);
    if (cfg_base_q == itp_pkg::BASE_ONE || cfg_base_q > itp_pkg::BASE_MAX) return 1'b1;
    if (c == itp_pkg::CH_0 &&
        (cfg_base_q == itp_pkg::BASE_AUTO || cfg_base_q == itp_pkg::BASE_HEX)) begin
      p_have = 1'b1;
      p_acc = '0;
      p_base = (cfg_base_q == itp_pkg::BASE_HEX) ? itp_pkg::BASE_HEX : itp_pkg::BASE_OCT;
      bump_position();
      p_state = ST_ZERO;
      return 1'b0;
    end
    p_base = (cfg_base_q == itp_pkg::BASE_AUTO) ? itp_pkg::BASE_DEC : cfg_base_q;
    p_state = ST_DIGITS;
    return !accept_digit(c);
  endfunction

  // advance the parser by one accepted character, queue any result
  task automatic parse_char(input logic [7:0] c, input bit start, input bit last);
    bit            ends;
    parse_result_t r;
    ends = 1'b0;
    if (start) begin
      p_state = ST_LEAD;
      p_neg = 1'b0;
      p_base = '0;
      p_acc = '0;
      p_ovf = 1'b0;
      p_have = 1'b0;
      p_pos = '0;
    end
    if (p_state != ST_DONE) begin
      live_chars++;
      case (p_state)
        ST_LEAD: begin
          if (c == itp_pkg::CH_SPACE || (c >= itp_pkg::CH_TAB && c <= itp_pkg::CH_CR)) begin
            bump_position();
          end else if (c == itp_pkg::CH_PLUS || c == itp_pkg::CH_MINUS) begin
            p_neg = (c == itp_pkg::CH_MINUS);
            bump_position();
            p_state = ST_SIGNED;
          end else begin
            ends = begin_number(c);
          end
        end
        ST_SIGNED: ends = begin_number(c);
        ST_ZERO: begin
          if (c == CH_LX || c == CH_UX) begin
            p_state = ST_XSEEN;
          end else begin
            p_state = ST_DIGITS;
            ends = !accept_digit(c);
          end
        end
        ST_XSEEN: begin
          if (digit_value(c) < itp_pkg::BASE_HEX) begin
            p_base = itp_pkg::BASE_HEX;
            bump_position();
            p_state = ST_DIGITS;
            ends = !accept_digit(c);
          end else begin
            ends = 1'b1;
          end
        end
        default: ends = !accept_digit(c);
      endcase
      // result: saturation, sign and count
      if (ends || last) begin
        r.value = '0;
        r.range_error = 1'b0;
        if (p_have) begin
          if (p_ovf) begin
            r.range_error = 1'b1;
            r.value = cfg_signed_q ? (p_neg ? SIGNED_MIN : SIGNED_MAX) : '1;
          end else begin
            r.value = p_neg ? 64'd0 - p_acc : p_acc;
          end
        end
        r.consumed = p_have ? p_pos : '0;
        r.digits_found = p_have;
        pending_results.push_back(r);
        p_state = ST_DONE;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking and output stall
  // ---------------------------------------------------------------------------

  task automatic check_parse_result();
    parse_result_t want;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result: value %h consumed %0d range %b digits %b",
                 out_value, out_consumed, out_range_error, out_digits_found);
    end else begin
      want = pending_results.pop_front();
      results_checked++;
      if (want.value !== out_value || want.consumed !== out_consumed ||
          want.range_error !== out_range_error ||
          want.digits_found !== out_digits_found) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result mismatch: expected %h/%0d/%b/%b got %h/%0d/%b/%b",
                   want.value, want.consumed, want.range_error, want.digits_found,
                   out_value, out_consumed, out_range_error, out_digits_found);
      end
    end
  endtask

  // check each result transfer, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_parse_result();
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one character transfer, with random idle cycles ahead of it
  task automatic send_char(input logic [7:0] c, input bit start, input bit last);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_chr <= c;
    in_start_req <= start;
    in_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_char(c, start, last);
  endtask

  task automatic send_text(input bit with_start, input bit with_last);
    int n;
    n = text_q.size();
    for (int i = 0; i < n; i++)
      send_char(text_q[i], with_start && i == 0, with_last && i == n - 1);
    text_q.delete();
    strings_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // hold the sender until every predicted result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [itp_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == itp_pkg::REG_BASE) cfg_base_q = data;
    else cfg_signed_q = data[0];
    cfg_writes++;
  endtask

  task automatic set_config(input logic [5:0] b, input bit s);
    wait_for_results();
    write_reg(itp_pkg::REG_BASE, b);
    write_reg(itp_pkg::REG_SIGNED, {5'd0, s});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] digit_char(input logic [5:0] d);
    if (d < itp_pkg::LETTER_OFS) return itp_pkg::CH_0 + 8'(d);
    return ($urandom_range(1) ? itp_pkg::CH_LA : itp_pkg::CH_UA) +
           8'(d - itp_pkg::LETTER_OFS);
  endfunction

  // whitespace, sign, optional prefix, then a value written in the base
  task automatic build_random_string(output bit with_last);
    logic [63:0] v;
    logic [5:0]  digs [0:63];
    int unsigned radix;
    int          n;
    text_q.delete();
    repeat ($urandom_range(2))
      text_q.push_back($urandom_range(4) == 0 ? itp_pkg::CH_SPACE
                                              : itp_pkg::CH_TAB + 8'($urandom_range(4)));
    case ($urandom_range(3))
      0: text_q.push_back(itp_pkg::CH_PLUS);
      1: text_q.push_back(itp_pkg::CH_MINUS);
      default: ;
    endcase
    if (cfg_base_q == itp_pkg::BASE_AUTO) begin
      case ($urandom_range(2))
        0: radix = itp_pkg::BASE_DEC;
        1: begin
          text_q.push_back(itp_pkg::CH_0);
          radix = itp_pkg::BASE_OCT;
        end
        default: begin
          text_q.push_back(itp_pkg::CH_0);
          text_q.push_back($urandom_range(1) ? CH_LX : CH_UX);
          radix = itp_pkg::BASE_HEX;
        end
      endcase
    end else if (cfg_base_q == itp_pkg::BASE_ONE || cfg_base_q > itp_pkg::BASE_MAX) begin
      radix = itp_pkg::BASE_DEC;
    end else begin
      radix = cfg_base_q;
      if (cfg_base_q == itp_pkg::BASE_HEX && $urandom_range(2) == 0) begin
        text_q.push_back(itp_pkg::CH_0);
        text_q.push_back($urandom_range(1) ? CH_LX : CH_UX);
      end
    end
    // value: small, full width, or close to the saturation points
    case ($urandom_range(5))
      0: v = 64'($urandom_range(99));
      1: v = {$urandom, $urandom};
      2: v = SIGNED_MAX - 64'($urandom_range(2)) + 64'($urandom_range(2));
      3: v = 64'hffff_ffff_ffff_ffff - 64'($urandom_range(2));
      4: v = {$urandom, $urandom} >> $urandom_range(63);
      default: v = 64'($urandom_range(9999));
    endcase
    n = 0;
    do begin
      digs[n] = 6'(v % 64'(radix));
      v = v / 64'(radix);
      n++;
    end while (v != 0);
    for (int i = n - 1; i >= 0; i--) text_q.push_back(digit_char(digs[i]));
    // extra digits push past the limit
    if ($urandom_range(4) == 0)
      repeat ($urandom_range(1, 3))
        text_q.push_back(digit_char(6'($urandom_range(radix - 1))));
    if ($urandom_range(9) == 0)
      text_q.insert($urandom_range(text_q.size()), 8'($urandom));
    // ending: string end, terminator with trailing bytes, or abandoned
    case ($urandom_range(5))
      0, 1, 2: with_last = 1'b1;
      3, 4: begin
        repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom));
        with_last = 1'b1;
      end
      default: with_last = 1'b0;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // parsing right after reset, without a start marker
  task automatic test_after_reset();
    add_text(" -42");
    send_text(1'b0, 1'b1);
    add_text("7");
    send_text(1'b1, 1'b1);
  endtask

  // auto base: prefixes, whitespace set, terminators, empty numbers; then hex base
  task automatic test_prefix_forms();
    set_config(itp_pkg::BASE_AUTO, 1'b1);
    add_text("0");
    send_text(1'b1, 1'b1);
    add_text("0xg");
    send_text(1'b1, 1'b1);
    add_text("+0X1f;");
    send_text(1'b1, 1'b1);
    add_text("017");
    send_text(1'b1, 1'b1);
    text_q = '{itp_pkg::CH_TAB, CH_LF, 8'h0B, 8'h0C, itp_pkg::CH_CR, itp_pkg::CH_SPACE,
               itp_pkg::CH_9};
    send_text(1'b1, 1'b1);
    text_q = '{8'h35, CH_NUL, itp_pkg::CH_9};
    send_text(1'b1, 1'b1);
    add_text("-z");
    send_text(1'b1, 1'b1);
    add_text("+");
    send_text(1'b1, 1'b1);
    set_config(itp_pkg::BASE_HEX, 1'b0);
    add_text("0x");
    send_text(1'b1, 1'b1);
    add_text("Ff");
    send_text(1'b1, 1'b1);
  endtask

  // a new start drops a string in progress; later bytes are ignored
  task automatic test_restart();
    set_config(itp_pkg::BASE_DEC, 1'b1);
    add_text("12");
    send_text(1'b1, 1'b0);
    add_text("34.");
    send_text(1'b1, 1'b1);
    send_char(8'hff, 1'b0, 1'b1);
    send_char(itp_pkg::CH_9, 1'b0, 1'b0);
  endtask

  // saturation in both modes, smallest signed value, negated unsigned
  task automatic test_saturation();
    set_config(itp_pkg::BASE_MAX, 1'b1);
    add_text("zzzzzzzzzzzzz");
    send_text(1'b1, 1'b1);
    add_text("-ZZZZZZZZZZZZZ9");
    send_text(1'b1, 1'b1);
    set_config(itp_pkg::BASE_HEX, 1'b1);
    add_text("-8000000000000000");
    send_text(1'b1, 1'b1);
    set_config(itp_pkg::BASE_HEX, 1'b0);
    add_text("ffffffffffffffff");
    send_text(1'b1, 1'b1);
    add_text("1ffffffffffffffff");
    send_text(1'b1, 1'b1);
    set_config(itp_pkg::BASE_DEC, 1'b0);
    add_text("-1");
    send_text(1'b1, 1'b1);
  endtask

  // bases that give no conversion
  task automatic test_invalid_base();
    set_config(itp_pkg::BASE_ONE, 1'b1);
    add_text("12");
    send_text(1'b1, 1'b1);
    set_config(6'h3f, 1'b0);
    add_text(" 12");
    send_text(1'b1, 1'b1);
  endtask

  // random strings across idling mixes and register settings
  task automatic test_random_strings();
    int unsigned target;
    logic [5:0]  b;
    bit          with_last;
    for (int mix = 0; mix < 4; mix++) begin
      wait_for_results();
      case (mix)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      target = live_chars + ITEMS_PER_MIX;
      while (live_chars < target) begin
        // new register setting now and then, with the block drained
        if ($urandom_range(39) == 0 || live_chars + ITEMS_PER_MIX == target) begin
          case ($urandom_range(9))
            1: b = itp_pkg::BASE_MIN;
            2: b = itp_pkg::BASE_OCT;
            3: b = itp_pkg::BASE_DEC;
            4: b = itp_pkg::BASE_HEX;
            5: b = itp_pkg::BASE_MAX;
            6: b = 6'($urandom_range(2, 36));
            8: b = $urandom_range(1) ? itp_pkg::BASE_ONE : 6'($urandom_range(37, 63));
            default: b = itp_pkg::BASE_AUTO;
          endcase
          set_config(b, 1'($urandom_range(1)));
        end
        build_random_string(with_last);
        send_text(1'b1, with_last);
        // loose bytes between strings
        if ($urandom_range(7) == 0)
          repeat ($urandom_range(1, 3))
            send_char(8'($urandom), 1'b0, 1'($urandom_range(1)));
      end
      add_text("1");
      send_text(1'b1, 1'b1);
    end
  endtask

  task automatic finish_run();
    int waited;
    idle_pct = 0;
    stall_pct = 0;
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      mismatch_count += pending_results.size();
    end
    $display("covered %0d strings (%0d parsed characters) under %0d register writes",
             strings_sent, live_chars, cfg_writes);
    $display("checked %0d results, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  endtask

  // reset, then tests in turn
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_after_reset();
    test_prefix_forms();
    test_restart();
    test_saturation();
    test_invalid_base();
    test_random_strings();
    finish_run();
  end

endmodule

// ===== sim.f =====
hw/rtl/itp_pkg.sv
hw/rtl/itp_front.sv
hw/rtl/itp_fifo.sv
hw/rtl/itp_back.sv
hw/rtl/integer_text_parser.sv
sim/tb_integer_text_parser.sv
